// ----- src/sss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned NML_W       = 8;
  localparam int unsigned SCORE_W     = 18;
  localparam int unsigned FULL_W      = 15;
  localparam int unsigned FULL_Q8     = 25600;
  localparam int unsigned IDENT_Q8    = 256000;
  localparam int unsigned NML_RESET   = 3;
  localparam int unsigned MAX_LEN_DEF = 256;

  typedef struct packed {
    logic [CHAR_W-1:0] char_a;
    logic [CHAR_W-1:0] char_b;
    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  len_b;
    logic              last;
  } sss_in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_q8;
    logic               identical;
  } sss_out_t;

  typedef struct packed {
    logic take;
    logic close;
    logic mul;
    logic step;
    logic fin;
    logic cfg_we;
  } sss_cmd_t;

  typedef struct packed {
    logic div_last;
  } sss_sts_t;

endpackage

`default_nettype wire

// ----- src/sss_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sss_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- src/sss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sss_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire logic            cfg_valid_i,
  input  wire sss_pkg::sss_sts_t sts_i,
  output sss_pkg::sss_cmd_t    cmd_o
);
  import sss_pkg::*;

  typedef enum logic [3:0] {
    ST_STREAM = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FIN    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_STREAM) && !(out_valid_q && in_last_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.take   = in_acc && !in_last_i;
    cmd_o.close  = in_acc && in_last_i;
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.fin    = (state_q == ST_FIN);
    cmd_o.cfg_we = cfg_valid_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_STREAM: begin
        if (in_acc && in_last_i) state_d = ST_MUL;
      end
      ST_MUL:    state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_FIN;
      end
      ST_FIN:    state_d = ST_STREAM;
      default:   state_d = ST_STREAM;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (state_q == ST_FIN) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_STREAM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_last_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> (state_q == ST_MUL))
    else $error("last transaction did not start the score calculation");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_FIN))
    else $error("divider finish not followed by result load");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside result load");

endmodule

`default_nettype wire

// ----- src/sss_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sss_dp #(
  parameter int unsigned MAX_LEN = sss_pkg::MAX_LEN_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sss_pkg::sss_cmd_t        cmd_i,
  input  wire sss_pkg::sss_in_t         in_data_i,
  input  wire logic [sss_pkg::NML_W-1:0] cfg_data_i,
  output sss_pkg::sss_sts_t             sts_o,
  output sss_pkg::sss_out_t             out_data_o
);
  import sss_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int unsigned POSS_W = LEN_W + 1;
  localparam int unsigned HIT_W  = CNT_W + 2;
  localparam int unsigned HC_W   = (HIT_W > POSS_W) ? HIT_W : POSS_W;
  localparam int unsigned NUM_W  = FULL_W + POSS_W;
  localparam int unsigned DCNT_W = $clog2(NUM_W);

  logic [NML_W-1:0]  nml_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CHAR_W-1:0] pa_q, pb_q, pb2_q;
  logic [CNT_W-1:0]  exact_q, near_q;
  logic              all_eq_q;

  logic [HC_W-1:0]   hits_q;
  logic [POSS_W-1:0] poss_q;
  logic              ident_q;
  logic [NUM_W-1:0]  quo_q;
  logic [POSS_W-1:0] rem_q;
  logic [DCNT_W-1:0] cnt_q;
  sss_out_t          out_q;

  logic [CMP_W-1:0]  la_x, lb_x, max_x, p_x, sh_x;
  logic [LEN_W-1:0]  la_c, lb_c, shorter;
  logic              pend, ahead_ok, behind_ok, cur, near_ok, eq_len;
  logic              e1, n1, e2, n2;
  logic [CNT_W:0]    ex_sum, nr_sum;
  logic [CNT_W-1:0]  ex_n, nr_n, pos_n;
  logic [HC_W-1:0]   hits_fin;
  logic [POSS_W-1:0] poss_fin;
  logic              all_eq_n;
  logic [POSS_W:0]   trial, trial_sub;
  logic              ge;

  always_comb begin
    max_x    = CMP_W'(MAX_LEN);
    la_x     = CMP_W'(in_data_i.len_a);
    lb_x     = CMP_W'(in_data_i.len_b);
    la_c     = LEN_W'((la_x > max_x) ? max_x : la_x);
    lb_c     = LEN_W'((lb_x > max_x) ? max_x : lb_x);
    shorter  = (la_c < lb_c) ? la_c : lb_c;
    sh_x     = CMP_W'(shorter);
    p_x      = CMP_W'(pos_q);
    eq_len   = (la_c == lb_c);
    near_ok  = la_c > LEN_W'(nml_q);

    // pending position p-1 scored now that the character ahead is known
    pend      = (pos_q != '0) && (p_x <= sh_x);
    ahead_ok  = p_x < CMP_W'(lb_c);
    behind_ok = p_x >= CMP_W'(2);
    cur       = in_data_i.last && (p_x < sh_x);

    e1 = pend && (pa_q == pb_q);
    n1 = pend && (pa_q != pb_q) && near_ok &&
         ((ahead_ok && (pa_q == in_data_i.char_b)) || (behind_ok && (pa_q == pb2_q)));
    e2 = cur && (in_data_i.char_a == in_data_i.char_b);
    n2 = cur && (in_data_i.char_a != in_data_i.char_b) && near_ok &&
         (pos_q != '0) && (in_data_i.char_a == pb_q);

    ex_sum = (CNT_W+1)'(exact_q) + (CNT_W+1)'(e1) + (CNT_W+1)'(e2);
    nr_sum = (CNT_W+1)'(near_q) + (CNT_W+1)'(n1) + (CNT_W+1)'(n2);
    ex_n   = (ex_sum > (CNT_W+1)'(MAX_LEN)) ? CNT_W'(MAX_LEN) : ex_sum[CNT_W-1:0];
    nr_n   = (nr_sum > (CNT_W+1)'(MAX_LEN)) ? CNT_W'(MAX_LEN) : nr_sum[CNT_W-1:0];
    pos_n  = (pos_q < CNT_W'(MAX_LEN)) ? pos_q + CNT_W'(1) : pos_q;

    all_eq_n = all_eq_q && (in_data_i.char_a == in_data_i.char_b);
    hits_fin = HC_W'(ex_n) + HC_W'(nr_n) + HC_W'(eq_len);
    poss_fin = POSS_W'(shorter) + POSS_W'(eq_len);
  end

  always_comb begin
    trial     = {rem_q, quo_q[NUM_W-1]};
    ge        = trial >= {1'b0, poss_q};
    trial_sub = trial - {1'b0, poss_q};
  end

  assign sts_o.div_last = (cnt_q == DCNT_W'(NUM_W - 1));
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nml_q <= NML_W'(NML_RESET);
    end else if (cmd_i.cfg_we) begin
      nml_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pa_q     <= '0;
      pb_q     <= '0;
      pb2_q    <= '0;
      exact_q  <= '0;
      near_q   <= '0;
      all_eq_q <= 1'b1;
    end else if (cmd_i.close) begin
      pos_q    <= '0;
      pa_q     <= '0;
      pb_q     <= '0;
      pb2_q    <= '0;
      exact_q  <= '0;
      near_q   <= '0;
      all_eq_q <= 1'b1;
    end else if (cmd_i.take) begin
      pos_q    <= pos_n;
      pa_q     <= in_data_i.char_a;
      pb_q     <= in_data_i.char_b;
      pb2_q    <= pb_q;
      exact_q  <= ex_n;
      near_q   <= nr_n;
      all_eq_q <= all_eq_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      hits_q  <= hits_fin;
      poss_q  <= poss_fin;
      ident_q <= all_eq_n && eq_len;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      quo_q <= NUM_W'(FULL_Q8) * NUM_W'(hits_q[POSS_W-1:0]);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? trial_sub[POSS_W-1:0] : trial[POSS_W-1:0];
      cnt_q <= cnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.identical <= ident_q;
      priority if (ident_q) begin
        out_q.score_q8 <= SCORE_W'(IDENT_Q8);
      end else if (hits_q == '0 || poss_q == '0) begin
        out_q.score_q8 <= '0;
      end else if (hits_q >= HC_W'(poss_q)) begin
        out_q.score_q8 <= SCORE_W'(FULL_Q8);
      end else begin
        out_q.score_q8 <= quo_q[SCORE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/string_similarity_score_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                  Transaction
// in_i     in   char_a, char_b, len_a, len_b, last       valid & ready
// out_o    out  score_q8, identical                      valid & ready
// cfg_i    in   near_min_length (8 bits)                 valid & ready
//
// One character pair per cycle while a string pair streams in.
// After the last pair: the numerator multiply, the restoring divider steps
// and the result load run in order before the next pair is taken.
// Async active-low reset; near_min_length resets to 3, cfg_i is always ready.
// A pending result stalls only a last pair, until out_o takes it.

module string_similarity_score_unit #(
  parameter int unsigned MAX_LEN = sss_pkg::MAX_LEN_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sss_chan_if.sink   in_i,
  sss_chan_if.source out_o,
  sss_chan_if.sink   cfg_i
);
  import sss_pkg::*;

  sss_cmd_t cmd;
  sss_sts_t sts;

  assign cfg_i.ready = 1'b1;

  sss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.data.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sss_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_i.data),
    .cfg_data_i (cfg_i.data),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sss_pkg::*;

  localparam int unsigned MAX_LEN      = MAX_LEN_DEF;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_PAIRS  = 225;
  localparam int unsigned NUM_PHASES   = 6;

  class score_tracker;
    logic [NML_W-1:0]  near_min;
    int unsigned       pos;
    int unsigned       exact_hits;
    int unsigned       near_hits;
    logic [CHAR_W-1:0] prev_a;
    logic [CHAR_W-1:0] prev_b;
    logic [CHAR_W-1:0] prev2_b;
    bit                all_equal;
    sss_out_t          pending_scores[$];
    int unsigned       errors;

    function new();
      near_min = NML_W'(NML_RESET);
      errors   = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      pos        = 0;
      exact_hits = 0;
      near_hits  = 0;
      prev_a     = '0;
      prev_b     = '0;
      prev2_b    = '0;
      all_equal  = 1'b1;
    endfunction

    function int unsigned sat_inc(int unsigned v);
      return (v < MAX_LEN) ? v + 1 : v;
    endfunction

    function void tally(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b, bit ahead_ok,
                        logic [CHAR_W-1:0] ahead, bit behind_ok,
                        logic [CHAR_W-1:0] behind, bit near_ok);
      if (a == b) begin
        exact_hits = sat_inc(exact_hits);
      end else if (near_ok && ((ahead_ok && a == ahead) || (behind_ok && a == behind))) begin
        near_hits = sat_inc(near_hits);
      end
    endfunction

    function void note_pair(sss_in_t p);
      int unsigned       la;
      int unsigned       lb;
      int unsigned       shorter;
      bit                near_ok;
      longint unsigned   hits;
      longint unsigned   spots;
      longint unsigned   score;
      sss_out_t          want;
      la      = (p.len_a > MAX_LEN) ? MAX_LEN : int'(p.len_a);
      lb      = (p.len_b > MAX_LEN) ? MAX_LEN : int'(p.len_b);
      shorter = (la < lb) ? la : lb;
      near_ok = la > near_min;
      // previous position is scored now that the next second-string byte is known
      if (pos >= 1 && pos - 1 < shorter)
        tally(prev_a, prev_b, pos < lb, p.char_b, pos >= 2, prev2_b, near_ok);
      if (p.char_a != p.char_b) all_equal = 1'b0;
      if (p.last) begin
        if (pos < shorter) tally(p.char_a, p.char_b, 1'b0, '0, pos >= 1, prev_b, near_ok);
        hits  = exact_hits + near_hits;
        spots = shorter;
        if (la == lb) begin
          hits++;
          spots++;
        end
        want.identical = all_equal && la == lb;
        if (want.identical) begin
          score = IDENT_Q8;
        end else if (hits == 0 || spots == 0) begin
          score = 0;
        end else begin
          score = (longint'(FULL_Q8) * hits) / spots;
          if (score > FULL_Q8) score = FULL_Q8;
        end
        want.score_q8 = score[SCORE_W-1:0];
        pending_scores.push_back(want);
        clear_stream();
      end else begin
        prev2_b = prev_b;
        prev_b  = p.char_b;
        prev_a  = p.char_a;
        pos     = sat_inc(pos);
      end
    endfunction

    function void check_score(sss_out_t got);
      sss_out_t want;
      if (pending_scores.size() == 0) begin
        $error("unexpected score: score_q8=%0d identical=%0d", got.score_q8, got.identical);
        errors++;
        return;
      end
      want = pending_scores.pop_front();
      if (got.score_q8 !== want.score_q8) begin
        $error("score_q8 mismatch: expected %0d, actual %0d", want.score_q8, got.score_q8);
        errors++;
      end
      if (got.identical !== want.identical) begin
        $error("identical mismatch: expected %0d, actual %0d", want.identical, got.identical);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sss_chan_if #(.payload_t(sss_in_t))          in_if ();
  sss_chan_if #(.payload_t(sss_out_t))         out_if ();
  sss_chan_if #(.payload_t(logic [NML_W-1:0])) cfg_if ();

  string_similarity_score_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  score_tracker      sb = new();
  int unsigned       gap_pct = 0;
  int unsigned       stall_pct = 0;
  bit                holding = 1'b0;
  event              start_hold;
  int unsigned       idle_cycles = 0;
  int unsigned       pairs_sent = 0;
  logic [CHAR_W-1:0] str_a[MAX_LEN];
  logic [CHAR_W-1:0] str_b[MAX_LEN];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !holding && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so that a finished pair backs up the input
  initial begin
    forever begin
      @(start_hold);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) sb.check_score(out_if.data);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL string_similarity_score_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pair(input sss_in_t p);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_pair(p);
    pairs_sent++;
  endtask

  task automatic send_stream(input int unsigned la, input int unsigned lb, input int unsigned n);
    sss_in_t p;
    for (int unsigned i = 0; i < n; i++) begin
      p.char_a = (i < la && i < MAX_LEN) ? str_a[i] : '0;
      p.char_b = (i < lb && i < MAX_LEN) ? str_b[i] : '0;
      p.len_a  = la[LEN_W-1:0];
      p.len_b  = lb[LEN_W-1:0];
      p.last   = (i == n - 1);
      send_pair(p);
    end
  endtask

  function automatic void fill_strings(input int unsigned style);
    bit wide;
    wide = $urandom_range(1);
    for (int i = 0; i < MAX_LEN; i++)
      str_a[i] = wide ? 8'($urandom_range(255)) : 8'($urandom_range(8'h64, 8'h61));
    for (int i = 0; i < MAX_LEN; i++) begin
      case (style)
        0: str_b[i] = str_a[i];
        1: str_b[i] = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : str_a[i];
        2: str_b[i] = (i > 0) ? str_a[i-1] : 8'($urandom_range(255));
        3: str_b[i] = (i < MAX_LEN - 1) ? str_a[i+1] : 8'($urandom_range(255));
        default: str_b[i] = wide ? 8'($urandom_range(255)) : 8'($urandom_range(8'h64, 8'h61));
      endcase
    end
  endfunction

  task automatic random_stream();
    int unsigned r;
    int unsigned la;
    int unsigned lb;
    int unsigned n;
    r  = $urandom_range(99);
    la = (r < 3) ? $urandom_range(256, 200) : $urandom_range(12);
    if ($urandom_range(1)) lb = la;
    else lb = (r < 3) ? $urandom_range(256, 200) : $urandom_range(12);
    n = (la > lb) ? la : lb;
    if (n == 0) n = 1;
    fill_strings($urandom_range(4));
    send_stream(la, lb, n);
  endtask

  task automatic send_noise();
    sss_in_t     p;
    int unsigned n;
    n = $urandom_range(20, 1);
    for (int unsigned i = 0; i < n; i++) begin
      p.char_a = 8'($urandom_range(255));
      p.char_b = ($urandom_range(1)) ? p.char_a : 8'($urandom_range(255));
      p.len_a  = 9'($urandom_range(511));
      p.len_b  = 9'($urandom_range(511));
      p.last   = (i == n - 1) || ($urandom_range(7) == 0);
      send_pair(p);
    end
  endtask

  task automatic write_near_min(input logic [NML_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    sb.near_min = v;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_scores.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned      phase_gap[NUM_PHASES];
    int unsigned      phase_stall[NUM_PHASES];
    logic [NML_W-1:0] phase_nml[NUM_PHASES];
    int unsigned      start;

    phase_gap   = '{0, 49, 0, 25, 0, 25};
    phase_stall = '{0, 0, 49, 25, 0, 25};
    phase_nml   = '{8'd0, 8'd255, 8'd3, 8'($urandom_range(255)), 8'd1,
                    8'($urandom_range(12))};

    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, near_min_length at its reset value
    send_stream(0, 0, 1);
    for (int i = 0; i < 3; i++) begin
      str_a[i] = 8'(8'h61 + i);
      str_b[i] = str_a[i];
    end
    send_stream(3, 3, 3);
    for (int i = 0; i < 5; i++) begin
      str_a[i] = 8'(i + 2);
      str_b[i] = 8'(i + 1);
    end
    send_stream(5, 5, 5);
    for (int i = 0; i < 5; i++) begin
      str_a[i] = 8'(i + 1);
      str_b[i] = 8'(i + 2);
    end
    send_stream(5, 5, 5);
    send_stream(3, 3, 3);
    send_pair('{char_a: 8'hFF, char_b: 8'h00, len_a: 9'd256, len_b: 9'd511, last: 1'b1});
    send_pair('{char_a: 8'h00, char_b: 8'hFF, len_a: 9'd0, len_b: 9'd256, last: 1'b1});
    send_pair('{char_a: 8'h41, char_b: 8'h41, len_a: 9'd4, len_b: 9'd2, last: 1'b0});
    send_pair('{char_a: 8'h42, char_b: 8'h43, len_a: 9'd1, len_b: 9'd3, last: 1'b1});
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_near_min(phase_nml[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      if (ph == 4) -> start_hold;
      if (ph == 0) begin
        // stream longer than the maximum length
        fill_strings(1);
        send_stream(MAX_LEN, MAX_LEN, MAX_LEN + 4);
      end
      start = pairs_sent;
      while (pairs_sent - start < PHASE_PAIRS) begin
        if ($urandom_range(99) < 15) send_noise();
        else random_stream();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS string_similarity_score_unit");
    end else begin
      $display("FAIL string_similarity_score_unit");
    end
    $finish;
  end

endmodule
